>>> sv/lcsfs_pkg.sv
// Shared types and constants for the LED chain SPI frame serializer.
package lcsfs_pkg;

    localparam int WORD_BITS = 16;
    localparam int MAX_CHAIN = 4;

    localparam logic [1:0] KIND_SINGLE    = 2'd0;
    localparam logic [1:0] KIND_BROADCAST = 2'd1;
    localparam logic [1:0] KIND_ROW       = 2'd2;
    localparam logic [1:0] KIND_RESERVED  = 2'd3;

    // Register address of the first digit (row) register.
    localparam logic [3:0] DIGIT0_REG = 4'h1;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] channel;
        logic [3:0] reg_addr;
        logic [7:0] data_0;
        logic [7:0] data_1;
        logic [7:0] data_2;
        logic [7:0] data_3;
    } t_cmd;

endpackage

>>> sv/lcsfs_frame_build.sv
// Combinational assembly of one left-aligned SPI frame from a write command.
module lcsfs_frame_build #(
    parameter int CHAIN_LENGTH = 4
) (
    input  lcsfs_pkg::t_cmd                                i_cmd,
    output logic [lcsfs_pkg::WORD_BITS*CHAIN_LENGTH-1:0]  o_frame
);

    localparam int FRAME_BITS = lcsfs_pkg::WORD_BITS * CHAIN_LENGTH;

    logic [7:0] w_data [lcsfs_pkg::MAX_CHAIN];
    logic [3:0] w_row_reg;

    assign w_data[0] = i_cmd.data_0;
    assign w_data[1] = i_cmd.data_1;
    assign w_data[2] = i_cmd.data_2;
    assign w_data[3] = i_cmd.data_3;

    // Row index wraps to three bits before the digit offset is added.
    assign w_row_reg = lcsfs_pkg::DIGIT0_REG + {1'b0, i_cmd.reg_addr[2:0]};

    for (genvar p = 0; p < CHAIN_LENGTH; p++) begin : g_pos
        logic [15:0] w_word;

        always_comb begin
            case (i_cmd.kind)
                lcsfs_pkg::KIND_SINGLE: begin
                    // A channel beyond the chain matches no position: all no-ops.
                    if (i_cmd.channel == 2'(p)) begin
                        w_word = {4'h0, i_cmd.reg_addr, i_cmd.data_0};
                    end else begin
                        w_word = '0;
                    end
                end
                lcsfs_pkg::KIND_BROADCAST: begin
                    w_word = {4'h0, i_cmd.reg_addr, i_cmd.data_0};
                end
                lcsfs_pkg::KIND_ROW: begin
                    w_word = {4'h0, w_row_reg, w_data[p]};
                end
                default: begin
                    w_word = '0;
                end
            endcase
        end

        assign o_frame[FRAME_BITS-1-lcsfs_pkg::WORD_BITS*p -: lcsfs_pkg::WORD_BITS] = w_word;
    end

endmodule

>>> sv/led_chain_spi_frame_serializer_core.sv
// Top level of the LED chain SPI frame serializer: command buffer and bit shifter.
//
//  Channel | Dir | tdata (low bit up)                                   | tuser | tlast
//  s       | in  | channel[1:0] reg_addr[3:0] data_0..data_3 [7:0], pad | kind  | -
//  m       | out | serial_bit, pad                                      | -     | frame_end
//
// One command yields 16*CHAIN_LENGTH output transactions, one bit per cycle from the frame
// shift register whenever the output is not stalled.
// A one-entry frame buffer takes the next command while the current frame shifts
// out; the buffered frame loads in the cycle the last bit is taken.
// Reserved-kind commands are accepted and dropped. Reset empties buffer and shifter.
// Backpressure on the output holds the shifter; input ready drops while the buffer is full.
module led_chain_spi_frame_serializer_core #(
    parameter int CHAIN_LENGTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // channel[1:0], reg_addr[5:2], data_0..data_3 [37:6], zeros
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // serial_bit[0], zeros
    output logic        m_tlast
);

    localparam int FRAME_BITS = lcsfs_pkg::WORD_BITS * CHAIN_LENGTH;
    localparam int CNT_W      = $clog2(FRAME_BITS + 1);

    lcsfs_pkg::t_cmd         w_cmd;
    logic [FRAME_BITS-1:0]   w_frame;

    logic [FRAME_BITS-1:0]   r_hold,  n_hold;
    logic                    r_hold_valid, n_hold_valid;
    logic [FRAME_BITS-1:0]   r_shift, n_shift;
    logic [CNT_W-1:0]        r_bits,  n_bits;

    logic in_acc, out_acc, out_last_acc, shift_load;

    assign w_cmd.kind     = s_tuser;
    assign w_cmd.channel  = s_tdata[1:0];
    assign w_cmd.reg_addr = s_tdata[5:2];
    assign w_cmd.data_0   = s_tdata[13:6];
    assign w_cmd.data_1   = s_tdata[21:14];
    assign w_cmd.data_2   = s_tdata[29:22];
    assign w_cmd.data_3   = s_tdata[37:30];

    lcsfs_frame_build #(
        .CHAIN_LENGTH(CHAIN_LENGTH)
    ) u_build (
        .i_cmd   (w_cmd),
        .o_frame (w_frame)
    );

    assign s_tready     = ~r_hold_valid;
    assign in_acc       = s_tvalid & s_tready;
    assign m_tvalid     = (r_bits != '0);
    assign m_tlast      = (r_bits == CNT_W'(1));
    assign m_tdata      = {7'b0, r_shift[FRAME_BITS-1]};
    assign out_acc      = m_tvalid & m_tready;
    assign out_last_acc = out_acc & m_tlast;
    assign shift_load   = r_hold_valid & (~m_tvalid | out_last_acc);

    always_comb begin
        n_hold       = r_hold;
        n_hold_valid = r_hold_valid;
        n_shift      = r_shift;
        n_bits       = r_bits;
        if (shift_load) begin
            n_hold_valid = 1'b0;
            n_shift      = r_hold;
            n_bits       = CNT_W'(FRAME_BITS);
        end else if (out_acc) begin
            n_shift = {r_shift[FRAME_BITS-2:0], 1'b0};
            n_bits  = r_bits - CNT_W'(1);
        end
        // The buffer is empty whenever a command is accepted, so no clash with the load.
        if (in_acc && (w_cmd.kind != lcsfs_pkg::KIND_RESERVED)) begin
            n_hold       = w_frame;
            n_hold_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_valid <= 1'b0;
            r_bits       <= '0;
        end else begin
            r_hold_valid <= n_hold_valid;
            r_bits       <= n_bits;
        end
        r_hold  <= n_hold;
        r_shift <= n_shift;
    end

`ifndef NO_ASSERTIONS
    a_bits_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bits <= CNT_W'(FRAME_BITS))
        else $error("bit counter above frame length");

    a_idle_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hold_valid && !m_tvalid) |=> (r_bits == CNT_W'(FRAME_BITS)))
        else $error("buffered frame not loaded into idle shifter");

    a_last_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_last_acc && !r_hold_valid) |=> !m_tvalid)
        else $error("output still valid after frame end with empty buffer");

    a_reserved_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && s_tuser == lcsfs_pkg::KIND_RESERVED) |=> !r_hold_valid)
        else $error("reserved command produced a frame");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tready) |=> ($stable(r_bits) && $stable(r_shift)))
        else $error("shifter moved during output stall");
`endif

endmodule
